FILE: rtl/complex_power_polar_defines.svh
// Assertion macros used by the checker file.
`ifndef COMPLEX_POWER_POLAR_DEFINES_SVH
`define COMPLEX_POWER_POLAR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CPP_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("complex_power_polar: check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CPP_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("complex_power_polar: check failed");

`endif

FILE: rtl/cpp_pkg.sv
`timescale 1ns / 1ps
package cpp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEPS = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
	localparam int LOG_BITS = 24;
	localparam int RED_STEPS = 10;

	localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;
	localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
	localparam logic signed [31:0] INV_GAIN_Q28 = 32'sd163008218;

	localparam logic [30:0] MANT_ONE = 31'h40000000;

	localparam logic signed [31:0] ATAN_HEAD [12] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
		32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072
	};

	localparam logic [30:0] EXP_ROOT [LOG_BITS] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
		31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
		31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181,
		31'd1073747502, 31'd1073744663, 31'd1073743244, 31'd1073742534,
		31'd1073742179, 31'd1073742001, 31'd1073741913, 31'd1073741868
	};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SAT      = 2'd1,
		ST_ZERO_NEG = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [31:0] z;
		logic signed [15:0] n;
		logic               zero;
	} vec_t;

	typedef struct packed {
		logic [33:0]        modv;
		logic signed [31:0] z;
		logic signed [15:0] n;
		logic               nul;
	} mod_t;

	typedef struct packed {
		logic [30:0]        f;
		logic [5:0]         p;
		logic [23:0]        frac;
		logic signed [31:0] z;
		logic signed [15:0] n;
		logic               nul;
	} log_t;

	typedef struct packed {
		logic signed [39:0] t;
		logic signed [39:0] ang;
		logic signed [15:0] n;
		logic               nul;
	} tm_t;

	typedef struct packed {
		logic [30:0]        mant;
		logic signed [15:0] e;
		logic [23:0]        fr;
		logic [39:0]        rem;
		logic               aneg;
		logic signed [15:0] n;
		logic               nul;
	} exp_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] rz;
		logic               flip;
		logic [30:0]        mant;
		logic signed [15:0] e;
		logic signed [15:0] n;
		logic               nul;
	} rot_t;

	typedef struct packed {
		logic signed [63:0] pre;
		logic signed [63:0] pim;
		logic signed [17:0] sh;
		logic signed [15:0] n;
		logic               nul;
	} prd_t;

	function automatic logic signed [31:0] atan_step(input int i);
		logic signed [31:0] a;
		if (i < 12) begin
			a = ATAN_HEAD[i];
		end else if (i < 30) begin
			a = ONE_Q28 >>> i;
		end else begin
			a = '0;
		end
		return a;
	endfunction

endpackage

FILE: rtl/cpp_ifs.sv
`timescale 1ns / 1ps
interface cpp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] real_in;
	logic signed [15:0] imag_in;
	logic signed [15:0] exponent;

	modport source (output valid, output real_in, output imag_in, output exponent,
		input ready);
	modport sink (input valid, input real_in, input imag_in, input exponent,
		output ready);
endinterface

interface cpp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] real_out;
	logic signed [31:0] imag_out;
	logic [1:0]         status;

	modport source (output valid, output real_out, output imag_out, output status,
		input ready);
	modport sink (input valid, input real_out, input imag_out, input status,
		output ready);
endinterface

FILE: rtl/complex_power_polar.sv
// Throughput: one item per cycle unless a result stalls; every stage of the vectoring,
// logarithm, exponential and rotation chains is a register stage with its own valid bit.
// A stalled result holds the whole pipeline in place; ready follows the output register.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
module complex_power_polar (
	input logic   clk,
	input logic   arst_n,
	cpp_in_if.sink    operand,
	cpp_out_if.source result
);
	import cpp_pkg::*;

	logic adv;

	vec_t vec_s [STEPS+1];
	logic vec_vld_s [STEPS+1];
	mod_t mod_s;
	logic mod_vld_s;
	log_t lg_s [LOG_BITS+1];
	logic lg_vld_s [LOG_BITS+1];
	tm_t  tm_s;
	logic tm_vld_s;
	exp_t ex_s [LOG_BITS+1];
	logic ex_vld_s [LOG_BITS+1];
	rot_t rt_s [STEPS+1];
	logic rt_vld_s [STEPS+1];
	prd_t pr_s;
	logic pr_vld_s;

	logic signed [31:0] res_re_s;
	logic signed [31:0] res_im_s;
	status_t            res_st_s;
	logic               res_vld_s;

	assign adv = !res_vld_s || result.ready;
	assign operand.ready = adv;

	vec_t in_v;
	always_comb begin
		in_v.x = 36'($signed({operand.real_in, 16'h0000}));
		in_v.y = 36'($signed({operand.imag_in, 16'h0000}));
		in_v.z = '0;
		in_v.n = operand.exponent;
		in_v.zero = (operand.real_in == 16'sd0) && (operand.imag_in == 16'sd0);
		if (in_v.x < 0) begin
			in_v.z = (in_v.y >= 0) ? PI_Q28 : -PI_Q28;
			in_v.x = -in_v.x;
			in_v.y = -in_v.y;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) vec_s[0] <= in_v;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vec_vld_s[0] <= 1'b0;
		else if (adv) vec_vld_s[0] <= operand.valid;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		vec_t nx;
		always_comb begin
			nx = vec_s[i];
			if (vec_s[i].y >= 0) begin
				nx.x = vec_s[i].x + (vec_s[i].y >>> i);
				nx.y = vec_s[i].y - (vec_s[i].x >>> i);
				nx.z = vec_s[i].z + atan_step(i);
			end else begin
				nx.x = vec_s[i].x - (vec_s[i].y >>> i);
				nx.y = vec_s[i].y + (vec_s[i].x >>> i);
				nx.z = vec_s[i].z - atan_step(i);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) vec_s[i+1] <= nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vec_vld_s[i+1] <= 1'b0;
			else if (adv) vec_vld_s[i+1] <= vec_vld_s[i];
		end
	end

	mod_t md_n;
	logic signed [63:0] mod_prod;
	always_comb begin
		mod_prod = 64'(vec_s[STEPS].x) * 64'(INV_GAIN_Q28);
		md_n.modv = vec_s[STEPS].zero ? '0 : mod_prod[61:28];
		md_n.z = vec_s[STEPS].z;
		md_n.n = vec_s[STEPS].n;
		md_n.nul = (md_n.modv == '0);
	end
	always_ff @(posedge clk) begin
		if (adv) mod_s <= md_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_vld_s <= 1'b0;
		else if (adv) mod_vld_s <= vec_vld_s[STEPS];
	end

	log_t lg_n;
	logic [63:0] norm;
	always_comb begin
		lg_n.p = '0;
		for (int b = 0; b < 34; b++) begin
			if (mod_s.modv[b]) lg_n.p = 6'(b);
		end
		if (lg_n.p >= 6'd30) norm = {30'b0, mod_s.modv} >> (lg_n.p - 6'd30);
		else norm = {30'b0, mod_s.modv} << (6'd30 - lg_n.p);
		lg_n.f = norm[30:0];
		lg_n.frac = '0;
		lg_n.z = mod_s.z;
		lg_n.n = mod_s.n;
		lg_n.nul = mod_s.nul;
	end
	always_ff @(posedge clk) begin
		if (adv) lg_s[0] <= lg_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_vld_s[0] <= 1'b0;
		else if (adv) lg_vld_s[0] <= mod_vld_s;
	end

	for (genvar k = 0; k < LOG_BITS; k++) begin : g_log
		log_t nx;
		logic [61:0] sq;
		always_comb begin
			nx = lg_s[k];
			sq = 62'(lg_s[k].f) * 62'(lg_s[k].f);
			if (sq[61]) begin
				nx.f = sq[61:31];
				nx.frac = {lg_s[k].frac[22:0], 1'b1};
			end else begin
				nx.f = sq[60:30];
				nx.frac = {lg_s[k].frac[22:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) lg_s[k+1] <= nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lg_vld_s[k+1] <= 1'b0;
			else if (adv) lg_vld_s[k+1] <= lg_vld_s[k];
		end
	end

	tm_t tm_n;
	logic signed [31:0] lgv;
	logic signed [47:0] tprod;
	logic signed [47:0] aprod;
	always_comb begin
		lgv = ((32'($signed({1'b0, lg_s[LOG_BITS].p})) - 32'sd28) <<< 24)
			+ $signed({8'b0, lg_s[LOG_BITS].frac});
		tprod = 48'(lgv) * 48'(lg_s[LOG_BITS].n);
		aprod = 48'(lg_s[LOG_BITS].z) * 48'(lg_s[LOG_BITS].n);
		tm_n.t = tprod[47:8];
		tm_n.ang = aprod[47:8];
		tm_n.n = lg_s[LOG_BITS].n;
		tm_n.nul = lg_s[LOG_BITS].nul;
	end
	always_ff @(posedge clk) begin
		if (adv) tm_s <= tm_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tm_vld_s <= 1'b0;
		else if (adv) tm_vld_s <= lg_vld_s[LOG_BITS];
	end

	exp_t ex_n;
	always_comb begin
		ex_n.mant = MANT_ONE;
		ex_n.e = tm_s.t[39:24];
		ex_n.fr = tm_s.t[23:0];
		ex_n.aneg = tm_s.ang[39];
		ex_n.rem = tm_s.ang[39] ? 40'(-tm_s.ang) : 40'(tm_s.ang);
		ex_n.n = tm_s.n;
		ex_n.nul = tm_s.nul;
	end
	always_ff @(posedge clk) begin
		if (adv) ex_s[0] <= ex_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ex_vld_s[0] <= 1'b0;
		else if (adv) ex_vld_s[0] <= tm_vld_s;
	end

	for (genvar i = 0; i < LOG_BITS; i++) begin : g_exp
		exp_t nx;
		logic [61:0] pm;
		always_comb begin
			nx = ex_s[i];
			pm = 62'(ex_s[i].mant) * 62'(EXP_ROOT[i]);
			if (ex_s[i].fr[LOG_BITS-1-i]) nx.mant = pm[60:30];
		end
		if (i < RED_STEPS) begin : g_red
			exp_t rx;
			logic [40:0] c;
			always_comb begin
				rx = nx;
				c = 41'($unsigned(TWO_PI_Q28)) << (RED_STEPS - 1 - i);
				if ({1'b0, ex_s[i].rem} >= c) rx.rem = ex_s[i].rem - c[39:0];
			end
			always_ff @(posedge clk) begin
				if (adv) ex_s[i+1] <= rx;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) ex_s[i+1] <= nx;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ex_vld_s[i+1] <= 1'b0;
			else if (adv) ex_vld_s[i+1] <= ex_vld_s[i];
		end
	end

	rot_t rt_n;
	logic signed [32:0] rr;
	always_comb begin
		rr = $signed({1'b0, ex_s[LOG_BITS].rem[31:0]});
		if (ex_s[LOG_BITS].aneg) rr = -rr;
		if (rr > 33'(PI_Q28)) rr = rr - 33'(TWO_PI_Q28);
		if (rr < -33'(PI_Q28)) rr = rr + 33'(TWO_PI_Q28);
		rt_n.flip = 1'b0;
		if (rr > 33'(HALF_PI_Q28)) begin
			rr = rr - 33'(PI_Q28);
			rt_n.flip = 1'b1;
		end else if (rr < -33'(HALF_PI_Q28)) begin
			rr = rr + 33'(PI_Q28);
			rt_n.flip = 1'b1;
		end
		rt_n.rz = rr[31:0];
		rt_n.cx = INV_GAIN_Q28;
		rt_n.cy = '0;
		rt_n.mant = ex_s[LOG_BITS].mant;
		rt_n.e = ex_s[LOG_BITS].e;
		rt_n.n = ex_s[LOG_BITS].n;
		rt_n.nul = ex_s[LOG_BITS].nul;
	end
	always_ff @(posedge clk) begin
		if (adv) rt_s[0] <= rt_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_vld_s[0] <= 1'b0;
		else if (adv) rt_vld_s[0] <= ex_vld_s[LOG_BITS];
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		rot_t nx;
		always_comb begin
			nx = rt_s[i];
			if (rt_s[i].rz >= 0) begin
				nx.cx = rt_s[i].cx - (rt_s[i].cy >>> i);
				nx.cy = rt_s[i].cy + (rt_s[i].cx >>> i);
				nx.rz = rt_s[i].rz - atan_step(i);
			end else begin
				nx.cx = rt_s[i].cx + (rt_s[i].cy >>> i);
				nx.cy = rt_s[i].cy - (rt_s[i].cx >>> i);
				nx.rz = rt_s[i].rz + atan_step(i);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) rt_s[i+1] <= nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_vld_s[i+1] <= 1'b0;
			else if (adv) rt_vld_s[i+1] <= rt_vld_s[i];
		end
	end

	prd_t pr_n;
	logic signed [31:0] fcx;
	logic signed [31:0] fcy;
	logic signed [31:0] mant_sg;
	always_comb begin
		fcx = rt_s[STEPS].flip ? -rt_s[STEPS].cx : rt_s[STEPS].cx;
		fcy = rt_s[STEPS].flip ? -rt_s[STEPS].cy : rt_s[STEPS].cy;
		mant_sg = $signed({1'b0, rt_s[STEPS].mant});
		pr_n.pre = 64'(mant_sg) * 64'(fcx);
		pr_n.pim = 64'(mant_sg) * 64'(fcy);
		pr_n.sh = 18'sd42 - 18'(rt_s[STEPS].e);
		pr_n.n = rt_s[STEPS].n;
		pr_n.nul = rt_s[STEPS].nul;
	end
	always_ff @(posedge clk) begin
		if (adv) pr_s <= pr_n;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pr_vld_s <= 1'b0;
		else if (adv) pr_vld_s <= rt_vld_s[STEPS];
	end

	logic signed [31:0] vr;
	logic signed [31:0] vi;
	logic               sr;
	logic               si;

	cpp_round_sat u_round_re (.prod(pr_s.pre), .shift(pr_s.sh), .value(vr), .sat(sr));
	cpp_round_sat u_round_im (.prod(pr_s.pim), .shift(pr_s.sh), .value(vi), .sat(si));

	logic signed [31:0] re_n;
	logic signed [31:0] im_n;
	status_t            st_n;
	always_comb begin
		if (pr_s.nul) begin
			re_n = (pr_s.n == 16'sd0) ? 32'sd65536 : 32'sd0;
			im_n = '0;
			st_n = (pr_s.n < 16'sd0) ? ST_ZERO_NEG : ST_OK;
		end else begin
			re_n = vr;
			im_n = vi;
			st_n = (sr || si) ? ST_SAT : ST_OK;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_re_s <= re_n;
			res_im_s <= im_n;
			res_st_s <= st_n;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_vld_s <= 1'b0;
		else if (adv) res_vld_s <= pr_vld_s;
	end

	assign result.valid = res_vld_s;
	assign result.real_out = res_re_s;
	assign result.imag_out = res_im_s;
	assign result.status = res_st_s;
endmodule

FILE: rtl/cpp_round_sat.sv
`timescale 1ns / 1ps
module cpp_round_sat (
	input  logic signed [63:0] prod,
	input  logic signed [17:0] shift,
	output logic signed [31:0] value,
	output logic               sat
);
	logic signed [64:0] p65;
	logic signed [64:0] sum;
	logic signed [64:0] shr;
	logic signed [64:0] shl;
	logic signed [64:0] lim_hi;
	logic signed [64:0] lim_lo;
	logic signed [17:0] kneg;
	logic [5:0]         sa;
	logic [4:0]         ka;

	always_comb begin
		p65 = 65'(prod);
		sa = shift[5:0];
		kneg = -shift;
		ka = kneg[4:0];
		sum = p65 + (65'sd1 <<< (sa - 6'd1));
		shr = sum >>> sa;
		shl = p65 <<< ka;
		lim_hi = 65'sd2147483647 >>> ka;
		lim_lo = -(65'sd2147483648 >>> ka);
		value = '0;
		sat = 1'b0;
		if (prod == 64'sd0) begin
			value = '0;
		end else if (shift >= 18'sd63) begin
			value = '0;
		end else if (shift >= 18'sd1) begin
			if (shr > 65'sd2147483647) begin
				sat = 1'b1;
				value = 32'sh7fffffff;
			end else if (shr < -65'sd2147483648) begin
				sat = 1'b1;
				value = 32'sh80000000;
			end else begin
				value = shr[31:0];
			end
		end else if (kneg >= 18'sd31) begin
			sat = 1'b1;
			value = (prod > 64'sd0) ? 32'sh7fffffff : 32'sh80000000;
		end else if (p65 > lim_hi) begin
			sat = 1'b1;
			value = 32'sh7fffffff;
		end else if (p65 < lim_lo) begin
			sat = 1'b1;
			value = 32'sh80000000;
		end else begin
			value = shl[31:0];
		end
	end
endmodule

FILE: rtl/cpp_checker.sv
`timescale 1ns / 1ps
`include "complex_power_polar_defines.svh"
module cpp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] real_out,
	input logic signed [31:0] imag_out,
	input logic [1:0]         status
);
	import cpp_pkg::*;

	`CPP_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
	`CPP_ASSERT_NXT(a_hold_on_stall, out_valid && !out_ready,
		out_valid && $stable(real_out) && $stable(imag_out) && $stable(status))
	`CPP_ASSERT_IMP(a_zero_neg_parts, out_valid && status == ST_ZERO_NEG,
		real_out == 32'sd0 && imag_out == 32'sd0)
	`CPP_ASSERT_IMP(a_sat_at_limit, out_valid && status == ST_SAT,
		real_out == 32'sh7fffffff || real_out == 32'sh80000000 ||
		imag_out == 32'sh7fffffff || imag_out == 32'sh80000000)
endmodule

bind complex_power_polar cpp_checker u_cpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (operand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.real_out  (result.real_out),
	.imag_out  (result.imag_out),
	.status    (result.status)
);

FILE: bench/complex_power_polar_test.sv
`timescale 1ns / 1ps
module complex_power_polar_test;
	import cpp_pkg::*;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic signed [15:0] n;
	} operand_t;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		status_t            st;
	} power_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpp_in_if operand_ch ();
	cpp_out_if result_ch ();

	complex_power_polar dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_ch),
		.result(result_ch)
	);

	always #4 clk = ~clk;

	operand_t pending_q[$];
	power_t powers_due[$];
	int mismatches = 0;
	int results_seen = 0;
	int saturated_seen = 0;
	int zero_neg_seen = 0;
	int sent = 0;
	logic took = 1'b0;
	int send_gap = 0;
	int hold_gap = 0;
	bit calm = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic longint to_q16(input longint p, input longint s, inout bit sat);
		longint v;
		longint k;
		if (p == 0) begin
			return 0;
		end
		if (s >= 63) begin
			v = 0;
		end else if (s >= 1) begin
			v = (p + (64'sd1 <<< (s - 1))) >>> s;
		end else begin
			k = -s;
			if (k >= 31) begin
				sat = 1'b1;
				return (p > 0) ? 64'sd2147483647 : -64'sd2147483648;
			end
			if (p > (64'sd2147483647 >>> k)) begin
				sat = 1'b1;
				return 64'sd2147483647;
			end
			if (p < -((64'sd1 <<< 31) >>> k)) begin
				sat = 1'b1;
				return -64'sd2147483648;
			end
			v = p <<< k;
		end
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic power_t raise_power(input operand_t op);
		power_t r;
		longint x, y, z, tx, md, lg, t, e, fr, ang, rm, cx, cy, rz, frac, a, n;
		longint unsigned mant, f, m;
		bit flip, sat;
		int p;
		x = longint'(op.re) * 65536;
		y = longint'(op.im) * 65536;
		z = 0;
		n = longint'(op.n);
		flip = 1'b0;
		sat = 1'b0;
		mant = 64'd1 << 30;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
			x = -x;
			y = -y;
		end
		if (op.re != 0 || op.im != 0) begin
			for (int i = 0; i < STEPS; i++) begin
				tx = x;
				a = longint'(atan_step(i));
				if (y >= 0) begin
					x = x + (y >>> i);
					y = y - (tx >>> i);
					z += a;
				end else begin
					x = x - (y >>> i);
					y = y + (tx >>> i);
					z -= a;
				end
			end
		end
		md = (op.re != 0 || op.im != 0) ? ((x * longint'(INV_GAIN_Q28)) >>> 28) : 0;
		if (md <= 0) begin
			r.re = (n == 0) ? 32'sd65536 : 32'sd0;
			r.im = '0;
			r.st = (n < 0) ? ST_ZERO_NEG : ST_OK;
			return r;
		end
		m = md;
		p = 63;
		while (p > 0 && m[p] == 1'b0) begin
			p--;
		end
		f = (p >= 30) ? (m >> (p - 30)) : (m << (30 - p));
		frac = 0;
		for (int k = 0; k < LOG_BITS; k++) begin
			f = (f * f) >> 30;
			frac = frac << 1;
			if (f >= (64'd1 << 31)) begin
				f = f >> 1;
				frac = frac | 1;
			end
		end
		lg = longint'(p - 28) * (64'sd1 <<< LOG_BITS) + frac;
		t = (lg * n) >>> 8;
		e = t >>> LOG_BITS;
		fr = t - e * (64'sd1 <<< LOG_BITS);
		for (int i = 0; i < 24; i++) begin
			if (fr[23 - i]) begin
				mant = (mant * longint'(EXP_ROOT[i])) >> 30;
			end
		end
		ang = (z * n) >>> 8;
		rm = ang % longint'(TWO_PI_Q28);
		if (rm > longint'(PI_Q28)) begin
			rm -= longint'(TWO_PI_Q28);
		end
		if (rm < -longint'(PI_Q28)) begin
			rm += longint'(TWO_PI_Q28);
		end
		if (rm > longint'(HALF_PI_Q28)) begin
			rm -= longint'(PI_Q28);
			flip = 1'b1;
		end else if (rm < -longint'(HALF_PI_Q28)) begin
			rm += longint'(PI_Q28);
			flip = 1'b1;
		end
		cx = longint'(INV_GAIN_Q28);
		cy = 0;
		rz = rm;
		for (int i = 0; i < STEPS; i++) begin
			tx = cx;
			a = longint'(atan_step(i));
			if (rz >= 0) begin
				cx = cx - (cy >>> i);
				cy = cy + (tx >>> i);
				rz -= a;
			end else begin
				cx = cx + (cy >>> i);
				cy = cy - (tx >>> i);
				rz += a;
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		r.re = 32'(to_q16(longint'(mant) * cx, 42 - e, sat));
		r.im = 32'(to_q16(longint'(mant) * cy, 42 - e, sat));
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_part();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return '0;
		end else if (r < 70) begin
			return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
		end
		return 16'($urandom);
	endfunction

	function automatic logic signed [15:0] pick_exponent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 16'sd256 * $signed(16'($urandom_range(0, 8))) - 16'sd1024;
		end else if (r < 85) begin
			return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
		end
		return 16'($urandom);
	endfunction

	task automatic add_operand(input logic signed [15:0] re, input logic signed [15:0] im,
		input logic signed [15:0] n);
		operand_t op;
		op.re = re;
		op.im = im;
		op.n = n;
		pending_q.push_back(op);
	endtask

	always @(posedge clk) begin
		took <= operand_ch.valid && operand_ch.ready;
		if (arst_n && operand_ch.valid && operand_ch.ready) begin
			powers_due.push_back(raise_power('{operand_ch.real_in, operand_ch.imag_in,
				operand_ch.exponent}));
			sent++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (result_ch.status == ST_SAT) begin
				saturated_seen++;
			end
			if (result_ch.status == ST_ZERO_NEG) begin
				zero_neg_seen++;
			end
			if (powers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result re=%0d im=%0d status=%0d",
						result_ch.real_out, result_ch.imag_out, result_ch.status);
				end
			end else begin
				power_t want;
				want = powers_due.pop_front();
				if (result_ch.real_out !== want.re || result_ch.imag_out !== want.im ||
					result_ch.status !== want.st) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected re=%0d im=%0d status=%0d,",
							want.re, want.im, want.st);
						$display("          got re=%0d im=%0d status=%0d",
							result_ch.real_out, result_ch.imag_out, result_ch.status);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!operand_ch.valid || took) begin
				if (send_gap > 0) begin
					operand_ch.valid <= 1'b0;
					send_gap--;
				end else if (pending_q.size() > 0) begin
					operand_t op;
					op = pending_q.pop_front();
					operand_ch.real_in <= op.re;
					operand_ch.imag_in <= op.im;
					operand_ch.exponent <= op.n;
					operand_ch.valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					operand_ch.valid <= 1'b0;
				end
			end
			if (hold_gap > 0) begin
				result_ch.ready <= 1'b0;
				hold_gap--;
			end else begin
				result_ch.ready <= 1'b1;
				hold_gap = pick_gap();
			end
			if ($urandom_range(0, 199) == 0) begin
				calm = ~calm;
			end
		end
	end

	initial begin
		operand_ch.valid = 1'b0;
		operand_ch.real_in = '0;
		operand_ch.imag_in = '0;
		operand_ch.exponent = '0;
		result_ch.ready = 1'b0;
		add_operand(16'sd0, 16'sd0, -16'sd256);
		add_operand(16'sd0, 16'sd0, 16'sd0);
		add_operand(16'sd0, 16'sd0, 16'sd512);
		add_operand(16'sd4096, 16'sd0, 16'sd512);
		add_operand(16'sd0, 16'sd4096, 16'sd512);
		add_operand(-16'sd4096, 16'sd0, 16'sd256);
		add_operand(-16'sd4096, -16'sd1, 16'sd384);
		add_operand(16'sd4096, 16'sd4096, -16'sd256);
		add_operand(16'sd32767, 16'sd32767, 16'sd32767);
		add_operand(-16'sd32768, -16'sd32768, 16'sd32767);
		add_operand(-16'sd32768, 16'sd32767, -16'sd32768);
		add_operand(16'sd1, 16'sd0, 16'sd32767);
		add_operand(16'sd1, -16'sd1, -16'sd32768);
		add_operand(16'sd1, 16'sd1, 16'sd2560);
		add_operand(16'sd32767, 16'sd0, 16'sd2560);
		add_operand(-16'sd32768, 16'sd0, 16'sd1280);
		add_operand(16'sd0, -16'sd32768, 16'sd128);
		add_operand(16'sd2048, -16'sd2048, -16'sd32768);
		add_operand(-16'sd1, 16'sd0, 16'sd0);
		add_operand(16'sd12345, -16'sd23456, 16'sd1);
		for (int i = 0; i < 650; i++) begin
			add_operand(pick_part(), pick_part(), pick_exponent());
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_q.size() != 0 || operand_ch.valid) begin
			@(negedge clk);
		end
		while (powers_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (2 * STEPS + 100) @(negedge clk);
		$display("Sent %0d operands and checked %0d results,", sent, results_seen);
		$display("%0d of them saturated and %0d were zero to a negative power.",
			saturated_seen, zero_neg_seen);
		if (mismatches == 0 && powers_due.size() == 0) begin
			$display("complex_power_polar regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing.", mismatches, powers_due.size());
			$display("complex_power_polar regression: fail");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("complex_power_polar regression: fail");
		$finish;
	end

endmodule

FILE: complex_power_polar.f
+incdir+rtl
rtl/cpp_pkg.sv
rtl/cpp_ifs.sv
rtl/cpp_round_sat.sv
rtl/complex_power_polar.sv
rtl/cpp_checker.sv
bench/complex_power_polar_test.sv
